// File: rtl/mtf_pkg.sv
package mtf_pkg;

	// Default list depth
	localparam int CapacityDef = 16;
	// Most results a dump gives
	localparam int MaxResults  = 16;

	// Field widths
	localparam int KeyW  = 32;
	localparam int PosW  = 4;
	localparam int TdW   = 40;

	typedef logic [KeyW-1:0] mtf_key_t;
	typedef logic [PosW-1:0] mtf_pos_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_MOVE   = 2'd2,
		OP_DUMP   = 2'd3
	} mtf_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} mtf_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_EMIT
	} mtf_state_t;

	// One result word handed from the sequencer to the output register
	typedef struct packed {
		logic        load;
		mtf_status_t status;
		mtf_key_t    key;
		mtf_pos_t    pos;
		logic        last;
	} mtf_res_t;

endpackage

// File: rtl/mtf_mem.sv
module mtf_mem #(
	parameter int DEPTH = mtf_pkg::CapacityDef,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wen,
	input  logic [AW-1:0]        waddr,
	input  mtf_pkg::mtf_key_t    wdata,
	input  logic                 ren,
	input  logic [AW-1:0]        raddr,
	output mtf_pkg::mtf_key_t    rdata
);
	import mtf_pkg::*;

	mtf_key_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/mtf_ctrl.sv
module mtf_ctrl #(
	parameter int CAPACITY = mtf_pkg::CapacityDef,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mtf_pkg::mtf_op_t     in_op,
	input  mtf_pkg::mtf_key_t    in_key,
	input  logic                 out_free,
	output mtf_pkg::mtf_res_t    res,
	output logic                 mem_wen,
	output logic [AW-1:0]        mem_waddr,
	output mtf_pkg::mtf_key_t    mem_wdata,
	output logic                 mem_ren,
	output logic [AW-1:0]        mem_raddr,
	input  mtf_pkg::mtf_key_t    mem_rdata
);
	import mtf_pkg::*;

	mtf_state_t  state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic        rv_q, rv_d;
	mtf_op_t     op_q, op_d;
	mtf_key_t    key_q, key_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	mtf_status_t st_q, st_d;
	logic [AW-1:0] ra_q, ra_d;

	logic          match;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] dump_lim;
	logic          dump_last;

	// Shared key comparator and walk pointer arithmetic
	assign match     = (mem_rdata == key_q);
	assign idx_dec   = idx_q - 1'b1;
	assign idx_inc   = idx_q + 1'b1;
	assign dump_lim  = (cnt_q > MaxResults) ? CW'(MaxResults) : cnt_q;
	assign dump_last = (idx_inc == dump_lim);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rv_q    <= rv_d;
		end
	end

	// Operand and walk registers
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		idx_q <= idx_d;
		pos_q <= pos_d;
		st_q  <= st_d;
		ra_q  <= ra_d;
	end

	// Sequencer
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rv_d      = 1'b0;
		op_d      = op_q;
		key_d     = key_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		st_d      = st_q;
		ra_d      = ra_q;
		in_ready  = 1'b0;
		res       = '0;
		mem_wen   = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		mem_ren   = 1'b0;
		mem_raddr = idx_q[AW-1:0];

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d  = in_op;
					key_d = in_key;
					idx_d = '0;
					pos_d = '0;
					case (in_op)
						OP_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								st_d    = ST_FULL;
								state_d = S_EMIT;
							end else begin
								idx_d   = cnt_q;
								state_d = S_SHIFT_DN;
							end
						end
						OP_REMOVE, OP_MOVE: begin
							state_d = S_SEARCH;
						end
						default: begin
							if (cnt_q == '0) begin
								st_d    = ST_EMPTY;
								key_d   = '0;
								state_d = S_EMIT;
							end else begin
								state_d = S_DUMP_RD;
							end
						end
					endcase
				end
			end

			// Walk from the front; compare each read word against the key
			S_SEARCH: begin
				if (rv_q && match) begin
					pos_d = CW'(ra_q);
					if (op_q == OP_REMOVE) begin
						idx_d   = CW'(ra_q) + 1'b1;
						state_d = S_SHIFT_UP;
					end else begin
						idx_d   = CW'(ra_q);
						state_d = S_SHIFT_DN;
					end
				end else if (idx_q < cnt_q) begin
					mem_ren   = 1'b1;
					mem_raddr = idx_q[AW-1:0];
					ra_d      = idx_q[AW-1:0];
					rv_d      = 1'b1;
					idx_d     = idx_inc;
				end else if (!rv_q) begin
					st_d    = ST_NOT_FOUND;
					pos_d   = '0;
					state_d = S_EMIT;
				end
			end

			// Move words one place back, then drop the key at the front
			S_SHIFT_DN: begin
				if (rv_q) begin
					mem_wen   = 1'b1;
					mem_waddr = ra_q + 1'b1;
					mem_wdata = mem_rdata;
				end
				if (idx_q != '0) begin
					mem_ren   = 1'b1;
					mem_raddr = idx_dec[AW-1:0];
					ra_d      = idx_dec[AW-1:0];
					rv_d      = 1'b1;
					idx_d     = idx_dec;
				end else if (!rv_q) begin
					mem_wen   = 1'b1;
					mem_waddr = '0;
					mem_wdata = key_q;
					if (op_q == OP_INSERT) begin
						cnt_d = cnt_q + 1'b1;
					end
					st_d    = ST_OK;
					state_d = S_EMIT;
				end
			end

			// Move the words behind the removed one place forward
			S_SHIFT_UP: begin
				if (rv_q) begin
					mem_wen   = 1'b1;
					mem_waddr = ra_q - 1'b1;
					mem_wdata = mem_rdata;
				end
				if (idx_q < cnt_q) begin
					mem_ren   = 1'b1;
					mem_raddr = idx_q[AW-1:0];
					ra_d      = idx_q[AW-1:0];
					rv_d      = 1'b1;
					idx_d     = idx_inc;
				end else if (!rv_q) begin
					cnt_d   = cnt_q - 1'b1;
					st_d    = ST_OK;
					state_d = S_EMIT;
				end
			end

			S_DUMP_RD: begin
				mem_ren   = 1'b1;
				mem_raddr = idx_q[AW-1:0];
				state_d   = S_DUMP_OUT;
			end

			// Hold the read word until the output register frees up
			S_DUMP_OUT: begin
				if (out_free) begin
					res.load   = 1'b1;
					res.status = ST_OK;
					res.key    = mem_rdata;
					res.pos    = mtf_pos_t'(idx_q);
					res.last   = dump_last;
					idx_d      = idx_inc;
					state_d    = dump_last ? S_IDLE : S_DUMP_RD;
				end
			end

			S_EMIT: begin
				if (out_free) begin
					res.load   = 1'b1;
					res.status = st_q;
					res.key    = key_q;
					res.pos    = mtf_pos_t'(pos_q);
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/move_to_front_key_list_core.sv
// Move-to-front key list engine.
// Input stream (s_*): one word per operation: insert at front, remove key,
// move key to front, or dump the list. Output stream (m_*): result words;
// every operation gives one word with tlast set, except a dump of a nonempty
// list, which gives one word per entry front to back (at most 16), tlast on
// the final one.
// Keys live in a single-port-write, registered-read RAM; one comparator and
// a small sequencer walk it one entry per cycle while searching or shifting,
// while a dump reads each entry and holds it until the output register frees.
// An insert into a list that is not full moves every entry one place back and
// writes the key at the front; a remove searches for the key and moves the
// entries behind it one place forward; a move to front searches for the key,
// moves the entries ahead of it one place back and writes it at the front.
// s_tready is high only while the sequencer is idle, so items are taken one at a time.
// Reset clears the entry count and the sequencer; RAM contents are not
// cleared and are never read before written.
// A stalled receiver holds m_tvalid and m_tdata in the output register; the
// sequencer waits on the next result word until that register is taken.
module move_to_front_key_list_core #(
	parameter int CAPACITY = mtf_pkg::CapacityDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [mtf_pkg::TdW-1:0]   s_tdata,  // operation[1:0], key[33:2], zero pad
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [mtf_pkg::TdW-1:0]   m_tdata,  // status[1:0], entry_key[33:2],
	                                            // position[37:34], zero pad
	output logic                      m_tlast
);
	import mtf_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	mtf_res_t      res;
	logic          out_free;
	logic          mem_wen;
	logic [AW-1:0] mem_waddr;
	mtf_key_t      mem_wdata;
	logic          mem_ren;
	logic [AW-1:0] mem_raddr;
	mtf_key_t      mem_rdata;

	logic          ovalid_q;
	mtf_status_t   ostatus_q;
	mtf_key_t      okey_q;
	mtf_pos_t      opos_q;
	logic          olast_q;

	mtf_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.CW      (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (mtf_op_t'(s_tdata[1:0])),
		.in_key   (s_tdata[KeyW+1:2]),
		.out_free (out_free),
		.res      (res),
		.mem_wen  (mem_wen),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_ren  (mem_ren),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	mtf_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.wen  (mem_wen),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.ren  (mem_ren),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign out_free = !ovalid_q || m_tready;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= res.load;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (res.load) begin
			ostatus_q <= res.status;
			okey_q    <= res.key;
			opos_q    <= res.pos;
			olast_q   <= res.last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(TdW - 2 - KeyW - PosW){1'b0}}, opos_q, okey_q, ostatus_q};
	assign m_tlast  = olast_q;

endmodule

// File: rtl/mtf_checker.sv
module mtf_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [mtf_pkg::TdW-1:0] m_tdata,
	input logic                    m_tlast
);
	import mtf_pkg::*;

	// Stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// An accepted operation drops s_tready, since the sequencer leaves idle to process it
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on back-to-back cycles");

	// Only a dump of entries gives words without tlast
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[1:0] == ST_OK)
		else $error("non-final word with error status");

	// Failed operations report position zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_NOT_FOUND || m_tdata[1:0] == ST_FULL
		|| m_tdata[1:0] == ST_EMPTY) |-> m_tdata[37:34] == '0)
		else $error("failed operation with nonzero position");

endmodule

bind move_to_front_key_list_core mtf_checker u_mtf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
